### design/tcs_pkg.sv
// Shared types and constants for the textured wall column stepper.
// Holds the queue entry layout, pixel kinds, texture codes and derived widths.
// No dependencies.
`default_nettype none

package tcs_pkg;

	localparam int SCREEN_HEIGHT = 512;
	localparam int TEX_HEIGHT    = 64;
	localparam int HALF_SCREEN   = SCREEN_HEIGHT / 2;

	localparam int IN_W  = 120;
	localparam int OUT_W = 64;

	localparam int DIV_W  = $clog2(TEX_HEIGHT + 1) + 16;
	localparam int TERM_W = 18;
	localparam int MAG_W  = TERM_W - 1;
	localparam int PROD_W = 32 + MAG_W;
	localparam int CNT_W  = $clog2(((DIV_W > MAG_W) ? DIV_W : MAG_W) + 1);

	localparam logic [DIV_W-1:0] DIVIDEND     = DIV_W'(TEX_HEIGHT * 65536);
	localparam logic [5:0]       TEX_ROW_MASK = 6'((TEX_HEIGHT - 1) & 63);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] TEX_WEST  = 2'd0;
	localparam logic [1:0] TEX_EAST  = 2'd1;
	localparam logic [1:0] TEX_NORTH = 2'd2;
	localparam logic [1:0] TEX_SOUTH = 2'd3;

	localparam logic REG_CEILING = 1'b0;
	localparam logic REG_FLOOR   = 1'b1;

	typedef enum logic [1:0] {
		KIND_CEILING = 2'd0,
		KIND_WALL    = 2'd1,
		KIND_FLOOR   = 2'd2
	} pixel_kind_t;

	typedef struct packed {
		logic [9:0]        column;
		logic [8:0]        row;
		pixel_kind_t       kind;
		logic              setup;
		logic [1:0]        choice;
		logic [15:0]       height;
		logic [TERM_W-1:0] term;
		logic [5:0]        tex_col;
	} item_t;

endpackage

`default_nettype wire

### design/textured_wall_column_stepper.sv
// Ordinary rows: accepted one per cycle while the queue is not full; each result is
// registered in the queue and then in the output register. Row 0 (column setup)
// runs the bit-serial divider and then the shift-add multiplier in the back end.
// Later rows queue behind it in a two-entry queue while setup runs.
// Reset (arst_n low, asynchronous) clears the colors, the column state and all
// control state; the output carries no beat until the first input beat.
`default_nettype none

module textured_wall_column_stepper
	import tcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// column_x, row_y, hit_side, cell_x, cell_y, player_x_pos, player_y_pos,
	// span_start, span_end, wall_height, texel_col, zero padding
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// out_column, out_row, texture_select, tex_col_out, tex_row_out,
	// fill_color, zero_height, zero padding
	output logic [OUT_W-1:0] m_tdata,
	// pixel_kind
	output logic [1:0]       m_tuser,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [23:0] ceiling_color_q;
	logic [23:0] floor_color_q;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_valid;
	item_t       front_item;
	item_t       head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FLOOR) ? {8'd0, floor_color_q} : {8'd0, ceiling_color_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_color_q <= '0;
			floor_color_q   <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_CEILING) begin
				ceiling_color_q <= pwdata[23:0];
			end else begin
				floor_color_q <= pwdata[23:0];
			end
		end
	end

	tcs_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.item     (front_item)
	);

	tcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head      (head),
		.not_empty (q_valid),
		.full      (q_full)
	);

	tcs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_valid       (q_valid),
		.pop           (pop),
		.ceiling_color (ceiling_color_q),
		.floor_color   (floor_color_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

endmodule

`default_nettype wire

### design/tcs_front.sv
// Front end: unpacks an input beat, classifies the row and prepares column setup terms.
// Depends on tcs_pkg.
`default_nettype none

module tcs_front
	import tcs_pkg::*;
(
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,
	input  logic            q_full,
	output logic            push,
	output item_t           item
);

	logic [9:0]  column_x;
	logic [8:0]  row_y;
	logic        hit_side;
	logic [9:0]  cell_x;
	logic [9:0]  cell_y;
	logic [17:0] player_x_pos;
	logic [17:0] player_y_pos;
	logic [9:0]  span_start;
	logic [9:0]  span_end;
	logic [15:0] wall_height;
	logic [5:0]  texel_col;

	assign column_x     = s_tdata[9:0];
	assign row_y        = s_tdata[18:10];
	assign hit_side     = s_tdata[19];
	assign cell_x       = s_tdata[29:20];
	assign cell_y       = s_tdata[39:30];
	assign player_x_pos = s_tdata[57:40];
	assign player_y_pos = s_tdata[75:58];
	assign span_start   = s_tdata[85:76];
	assign span_end     = s_tdata[95:86];
	assign wall_height  = s_tdata[111:96];
	assign texel_col    = s_tdata[117:112];

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		item.column  = column_x;
		item.row     = row_y;
		item.setup   = (row_y == 9'd0);
		item.height  = wall_height;
		item.tex_col = texel_col;
		item.term    = TERM_W'(span_start) - TERM_W'(HALF_SCREEN) + TERM_W'(wall_height[15:1]);
		if ({1'b0, row_y} <= span_start) begin
			item.kind = KIND_CEILING;
		end else if ({1'b0, row_y} <= span_end) begin
			item.kind = KIND_WALL;
		end else begin
			item.kind = KIND_FLOOR;
		end
		if (!hit_side) begin
			item.choice = ({cell_x, 8'd0} < player_x_pos) ? TEX_WEST : TEX_EAST;
		end else begin
			item.choice = ({cell_y, 8'd0} < player_y_pos) ? TEX_NORTH : TEX_SOUTH;
		end
	end

endmodule

`default_nettype wire

### design/tcs_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on tcs_pkg.
`default_nettype none

module tcs_queue
	import tcs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  not_empty,
	output logic  full
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/tcs_back.sv
// Back end: column setup (iterative divider and shift-add multiplier), texture
// stepping and the output register. Depends on tcs_pkg.
`default_nettype none

module tcs_back
	import tcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            head,
	input  logic             q_valid,
	output logic             pop,
	input  logic [23:0]      ceiling_color,
	input  logic [23:0]      floor_color,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic [1:0]       m_tuser
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_FIN,
		S_EMIT
	} state_t;

	state_t            state_q;
	item_t             cur_q;
	logic [31:0]       step_q;
	logic [31:0]       pos_q;
	logic [1:0]        choice_q;
	logic              zflag_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       rem_q;
	logic [DIV_W-1:0]  dq_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [MAG_W-1:0]  mplier_q;
	logic              neg_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;
	logic [1:0]        m_tuser_q;

	logic              out_free;
	logic              emit;
	item_t             emit_item;
	logic [16:0]       div_shift;
	logic [17:0]       div_diff;
	logic [15:0]       rem_next;
	logic [DIV_W-1:0]  dq_next;
	logic [31:0]       step_next;
	logic [TERM_W-1:0] term_abs;
	logic [PROD_W-1:0] acc_next;
	logic [31:0]       pos_setup;
	logic [5:0]        ip_low;
	logic [5:0]        tex_row;
	logic [33:0]       pos_sum;
	logic [31:0]       pos_adv;
	logic [5:0]        tcol;
	logic [23:0]       fill;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		out_free  = !m_tvalid_q || m_tready;
		emit_item = (state_q == S_EMIT) ? cur_q : head;
		pop       = (state_q == S_IDLE) && q_valid && (head.setup || out_free);
		emit      = ((state_q == S_IDLE) && q_valid && !head.setup && out_free) ||
			((state_q == S_EMIT) && out_free);

		div_shift = {rem_q, dq_q[DIV_W-1]};
		div_diff  = {1'b0, div_shift} - {2'b00, cur_q.height};
		rem_next  = div_diff[17] ? div_shift[15:0] : div_diff[15:0];
		dq_next   = {dq_q[DIV_W-2:0], !div_diff[17]};
		step_next = (cur_q.height == 16'd0) ? 32'hFFFF_FFFF : 32'(dq_next);

		term_abs = cur_q.term[TERM_W-1] ? (~cur_q.term + 1'b1) : cur_q.term;
		acc_next = acc_q + (mplier_q[0] ? mcand_q : '0);

		if (acc_q[PROD_W-1:31] != '0) begin
			pos_setup = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			pos_setup = neg_q ? (~acc_q[31:0] + 1'b1) : acc_q[31:0];
		end

		ip_low  = pos_q[21:16] + 6'(pos_q[31] && (pos_q[15:0] != 16'd0));
		tex_row = ip_low & TEX_ROW_MASK;
		pos_sum = {{2{pos_q[31]}}, pos_q} + {2'b00, step_q};
		pos_adv = (!pos_sum[33] && (pos_sum[32] || pos_sum[31])) ? 32'h7FFF_FFFF : pos_sum[31:0];

		tcol = '0;
		fill = '0;
		case (emit_item.kind)
			KIND_CEILING: fill = ceiling_color;
			KIND_WALL:    tcol = emit_item.tex_col;
			KIND_FLOOR:   fill = floor_color;
			default:      fill = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			pos_q      <= '0;
			choice_q   <= TEX_WEST;
			zflag_q    <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
				if (emit_item.kind == KIND_WALL) begin
					pos_q <= pos_adv;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop && head.setup) begin
						choice_q <= head.choice;
						cnt_q    <= CNT_W'(DIV_W - 1);
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						step_q  <= step_next;
						zflag_q <= (cur_q.height == 16'd0);
						cnt_q   <= CNT_W'(MAG_W - 1);
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					pos_q   <= pos_setup;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.setup) begin
			cur_q <= head;
			rem_q <= '0;
			dq_q  <= DIVIDEND;
		end
		if (state_q == S_DIV) begin
			rem_q <= rem_next;
			dq_q  <= dq_next;
			if (cnt_q == '0) begin
				acc_q    <= '0;
				mcand_q  <= PROD_W'(step_next);
				mplier_q <= term_abs[MAG_W-1:0];
				neg_q    <= cur_q.term[TERM_W-1];
			end
		end
		if (state_q == S_MUL) begin
			acc_q    <= acc_next;
			mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MAG_W-1:1]};
		end
		if (emit) begin
			m_tuser_q <= emit_item.kind;
			m_tdata_q <= {6'd0, zflag_q, fill,
				(emit_item.kind == KIND_WALL) ? tex_row : 6'd0,
				tcol, choice_q, emit_item.row, emit_item.column};
		end
	end

endmodule

`default_nettype wire
